// ----- hdl/pgr_pkg.sv -----
// Shared constants, codes and types of the PageRank engine.
package pgr_pkg;

    localparam int NODES_MAX = 1024;
    localparam int EDGES_MAX = 8192;
    localparam int NODE_W    = $clog2(NODES_MAX);
    localparam int EDGE_W    = $clog2(EDGES_MAX);
    localparam int NCNT_W    = NODE_W + 1;
    localparam int ECNT_W    = EDGE_W + 1;
    localparam int DEG_W     = EDGE_W + 1;
    localparam int RANK_W    = 32;          // Q0.32 ranks
    localparam int DIVD_W    = RANK_W + 1;
    localparam int DIVC_W    = $clog2(DIVD_W + 1);

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } pgr_kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOCONV  = 2'd3
    } pgr_status_t;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_DAMPING    = 2'd1;
    localparam logic [1:0] REG_TOLERANCE  = 2'd2;
    localparam logic [1:0] REG_MAX_ITER   = 2'd3;

    localparam logic [10:0] NODE_COUNT_RST = 11'd1;
    localparam logic [15:0] DAMPING_RST    = 16'd55706;
    localparam logic [31:0] TOLERANCE_RST  = 32'd429497;
    localparam logic [15:0] MAX_ITER_RST   = 16'd1000;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEG_W-1:0]  divisor;
    } pgr_div_req_t;

endpackage

// ----- hdl/pgr_in_if.sv -----
// Request channel of the PageRank engine.
interface pgr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] source_node;
    logic [9:0] target_node;
    logic [9:0] node_index;

    modport source (output valid, kind, source_node, target_node, node_index, input ready);
    modport sink   (input valid, kind, source_node, target_node, node_index, output ready);
endinterface

// ----- hdl/pgr_out_if.sv -----
// Result channel of the PageRank engine.
interface pgr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rank;
    logic [15:0] iterations;
    logic [1:0]  status;

    modport source (output valid, rank, iterations, status, input ready);
    modport sink   (input valid, rank, iterations, status, output ready);
endinterface

// ----- hdl/pgr_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module pgr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pgr_pkg::pgr_div_req_t       req,
    output logic                        busy,
    output logic [pgr_pkg::DIVD_W-1:0]  quotient
);

    logic [pgr_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [pgr_pkg::DEG_W-1:0]  rem_reg, rem_next;
    logic [pgr_pkg::DEG_W-1:0]  dsr_reg;
    logic [pgr_pkg::DIVC_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [pgr_pkg::DEG_W:0]    trial;
    logic                       ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[pgr_pkg::DIVD_W-1]};
        ge        = (trial >= {1'b0, dsr_reg});
        rem_next  = ge ? pgr_pkg::DEG_W'(trial - {1'b0, dsr_reg})
                       : trial[pgr_pkg::DEG_W-1:0];
        quo_next  = {quo_reg[pgr_pkg::DIVD_W-2:0], ge};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = (cnt_reg != pgr_pkg::DIVC_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= pgr_pkg::DIVC_W'(pgr_pkg::DIVD_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/pagerank_power_iteration.sv -----
// PageRank power-iteration engine: edge store, out-degrees, rank memories.
//
//  Port       | Dir | Handshake       | Carries
//  -----------+-----+-----------------+------------------------------------------
//  in_ch      | in  | valid/ready     | kind, source_node, target_node, node_index
//  out_ch     | out | valid/ready     | rank, iterations, status
//  APB        | in  | psel/penable    | node_count, damping, tolerance, max_iter
//
// A run: one shared serial divider per node per pass sets the node phase; the
//   edge phase steps through every edge by reads of the edge and rank memories.
// Reset: a sweep clears the out-degree memory; no request taken.
// Stalls: one request in flight; a finished result waits in the output
//   register and the next request is taken as it drains.
module pagerank_power_iteration (
    input  logic         clk,
    input  logic         rst_n,
    pgr_in_if.sink       in_ch,
    pgr_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NW = pgr_pkg::NODE_W;
    localparam int NC = pgr_pkg::NCNT_W;
    localparam int EW = pgr_pkg::EDGE_W;
    localparam int EC = pgr_pkg::ECNT_W;
    localparam int DW = pgr_pkg::DEG_W;
    localparam int RW = pgr_pkg::RANK_W;
    localparam logic [RW-1:0] RANK_MAX = '1;

    typedef enum logic [16:0] {
        S_CLR   = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_ADD   = 17'b00000000000000100,
        S_RDR   = 17'b00000000000001000,
        S_PREP0 = 17'b00000000000010000,
        S_PREP1 = 17'b00000000000100000,
        S_PREP2 = 17'b00000000001000000,
        S_INIT  = 17'b00000000010000000,
        S_A_RD  = 17'b00000000100000000,
        S_A_DIV = 17'b00000001000000000,
        S_A_WT  = 17'b00000010000000000,
        S_B_RD  = 17'b00000100000000000,
        S_B_LK  = 17'b00001000000000000,
        S_B_WR  = 17'b00010000000000000,
        S_C_RD  = 17'b00100000000000000,
        S_C_MUL = 17'b01000000000000000,
        S_C_WR  = 17'b10000000000000000
    } state_t;

    // S_PASS / S_DONE folded into dedicated flags below keep the enum small
    typedef enum logic [1:0] {
        F_NONE = 2'b01,
        F_DONE = 2'b10
    } fin_t;

    // ---------------- configuration ----------------
    logic [10:0] node_count_reg;
    logic [15:0] damping_reg;
    logic [31:0] tolerance_reg;
    logic [15:0] max_iter_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= pgr_pkg::NODE_COUNT_RST;
            damping_reg    <= pgr_pkg::DAMPING_RST;
            tolerance_reg  <= pgr_pkg::TOLERANCE_RST;
            max_iter_reg   <= pgr_pkg::MAX_ITER_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pgr_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[10:0];
                pgr_pkg::REG_DAMPING:    damping_reg    <= pwdata[15:0];
                pgr_pkg::REG_TOLERANCE:  tolerance_reg  <= pwdata;
                pgr_pkg::REG_MAX_ITER:   max_iter_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pgr_pkg::REG_NODE_COUNT: prdata = {21'd0, node_count_reg};
            pgr_pkg::REG_DAMPING:    prdata = {16'd0, damping_reg};
            pgr_pkg::REG_TOLERANCE:  prdata = tolerance_reg;
            pgr_pkg::REG_MAX_ITER:   prdata = {16'd0, max_iter_reg};
            default:                 prdata = '0;
        endcase
    end

    // active node count: 0 acts as 1, above the store size acts as full size
    logic [NC-1:0] n_act;
    logic [15:0]   cap;
    always_comb
    begin
        if (node_count_reg == '0)
            n_act = NC'(1);
        else if (node_count_reg > 11'(pgr_pkg::NODES_MAX))
            n_act = NC'(pgr_pkg::NODES_MAX);
        else
            n_act = NC'(node_count_reg);
        cap = (max_iter_reg == '0) ? 16'd1 : max_iter_reg;
    end

    // ---------------- memories ----------------
    logic [2*NW-1:0] edge_mem  [pgr_pkg::EDGES_MAX];
    logic [DW-1:0]   deg_mem   [pgr_pkg::NODES_MAX];
    logic [RW-1:0]   share_mem [pgr_pkg::NODES_MAX];
    logic [RW-1:0]   rnext_mem [pgr_pkg::NODES_MAX];
    logic [RW-1:0]   rcur_mem  [pgr_pkg::NODES_MAX];

    logic            edge_we, edge_re;
    logic [EW-1:0]   edge_wa, edge_ra;
    logic [2*NW-1:0] edge_wd, edge_q;
    logic            deg_we, deg_re;
    logic [NW-1:0]   deg_wa, deg_ra;
    logic [DW-1:0]   deg_wd, deg_q;
    logic            share_we, share_re;
    logic [NW-1:0]   share_wa, share_ra;
    logic [RW-1:0]   share_wd, share_q;
    logic            rnext_we, rnext_re;
    logic [NW-1:0]   rnext_wa, rnext_ra;
    logic [RW-1:0]   rnext_wd, rnext_q;
    logic            rcur_we, rcur_re;
    logic [NW-1:0]   rcur_wa, rcur_ra;
    logic [RW-1:0]   rcur_wd, rcur_q;

    always_ff @(posedge clk)
    begin
        if (edge_we)  edge_mem[edge_wa]   <= edge_wd;
        if (edge_re)  edge_q              <= edge_mem[edge_ra];
        if (deg_we)   deg_mem[deg_wa]     <= deg_wd;
        if (deg_re)   deg_q               <= deg_mem[deg_ra];
        if (share_we) share_mem[share_wa] <= share_wd;
        if (share_re) share_q             <= share_mem[share_ra];
        if (rnext_we) rnext_mem[rnext_wa] <= rnext_wd;
        if (rnext_re) rnext_q             <= rnext_mem[rnext_ra];
        if (rcur_we)  rcur_mem[rcur_wa]   <= rcur_wd;
        if (rcur_re)  rcur_q              <= rcur_mem[rcur_ra];
    end

    // ---------------- divider ----------------
    pgr_pkg::pgr_div_req_t         div_req;
    logic                          div_busy;
    logic [pgr_pkg::DIVD_W-1:0]    div_q;

    pgr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ---------------- control state ----------------
    state_t          state_reg, state_next;
    fin_t            fin_reg, fin_next;        // set while a finished run or clear awaits the output register
    logic [NC-1:0]   i_reg, i_next;
    logic [EC-1:0]   e_reg, e_next;
    logic [EC-1:0]   edge_count_reg, edge_count_next;
    logic            clr_report_reg, clr_report_next;
    logic [RW-1:0]   init_reg, init_next;
    logic [RW:0]     delta_reg, delta_next;
    logic [RW-1:0]   dang_reg, dang_next;
    logic [RW-1:0]   err_reg, err_next;
    logic [15:0]     passes_reg, passes_next;
    logic [15:0]     iter_reg, iter_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            flag_reg, flag_next;
    logic [NW-1:0]   tgt_reg, tgt_next;
    logic [NW-1:0]   src_reg, src_next;
    logic [47:0]     prod_reg, prod_next;

    logic            out_valid_reg;
    logic [RW-1:0]   out_rank_reg;
    logic [15:0]     out_iter_reg;
    logic [1:0]      out_status_reg;
    logic            out_free, in_acc, out_load;
    logic [RW-1:0]   load_rank;
    logic [15:0]     load_iter;
    logic [1:0]      load_status;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && (fin_reg == F_NONE) && out_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // datapath temporaries
    logic [RW:0]     sum_nd;
    logic [RW-1:0]   v1;
    logic [47:0]     rnd;
    logic [RW+1:0]   sum_vd;
    logic [RW-1:0]   v3, diff;
    logic [RW:0]     sum_dang, sum_share;
    logic [NW-1:0]   e_src, e_tgt;
    logic [15:0]     pn;
    logic            e_ok;

    always_comb
    begin
        state_next      = state_reg;
        fin_next        = fin_reg;
        i_next          = i_reg;
        e_next          = e_reg;
        edge_count_next = edge_count_reg;
        clr_report_next = clr_report_reg;
        init_next       = init_reg;
        delta_next      = delta_reg;
        dang_next       = dang_reg;
        err_next        = err_reg;
        passes_next     = passes_reg;
        iter_next       = iter_reg;
        res_status_next = res_status_reg;
        flag_next       = flag_reg;
        tgt_next        = tgt_reg;
        src_next        = src_reg;
        prod_next       = prod_reg;

        edge_we = 1'b0; edge_re = 1'b0; edge_wa = '0; edge_ra = '0; edge_wd = '0;
        deg_we = 1'b0;  deg_re = 1'b0;  deg_wa = '0;  deg_ra = '0;  deg_wd = '0;
        share_we = 1'b0; share_re = 1'b0; share_wa = '0; share_ra = '0; share_wd = '0;
        rnext_we = 1'b0; rnext_re = 1'b0; rnext_wa = '0; rnext_ra = '0; rnext_wd = '0;
        rcur_we = 1'b0; rcur_re = 1'b0; rcur_wa = '0; rcur_ra = '0; rcur_wd = '0;

        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, rcur_q};
        div_req.divisor  = (deg_q == '0) ? DW'(n_act) : deg_q;

        out_load    = 1'b0;
        load_rank   = '0;
        load_iter   = iter_reg;
        load_status = pgr_pkg::STAT_OK;

        e_src     = edge_q[2*NW-1:NW];
        e_tgt     = edge_q[NW-1:0];
        e_ok      = ({1'b0, e_src} < n_act) && ({1'b0, e_tgt} < n_act);
        sum_dang  = {1'b0, dang_reg} + {1'b0, div_q[RW-1:0]};
        sum_share = {1'b0, rnext_q} + {1'b0, share_q};
        sum_nd    = {1'b0, rnext_q} + {1'b0, dang_reg};
        v1        = sum_nd[RW] ? RANK_MAX : sum_nd[RW-1:0];
        rnd       = prod_reg + 48'h8000;
        sum_vd    = {2'b00, rnd[47:16]} + {1'b0, delta_reg};
        v3        = (sum_vd > {2'b00, RANK_MAX}) ? RANK_MAX : sum_vd[RW-1:0];
        diff      = (v3 > rcur_q) ? (v3 - rcur_q) : (rcur_q - v3);
        pn        = passes_reg + 16'd1;

        if (fin_reg == F_DONE)
        begin
            // a finished run or clear waits for the output register
            if (out_free)
            begin
                out_load    = 1'b1;
                load_status = res_status_reg;
                fin_next    = F_NONE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    deg_we          = 1'b1;
                    deg_wa          = i_reg[NW-1:0];
                    deg_wd          = '0;
                    edge_count_next = '0;
                    i_next          = i_reg + 1'b1;
                    if (i_reg == NC'(pgr_pkg::NODES_MAX - 1))
                    begin
                        i_next     = '0;
                        state_next = S_IDLE;
                        if (clr_report_reg)
                        begin
                            res_status_next = pgr_pkg::STAT_OK;
                            fin_next        = F_DONE;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_ch.kind)
                            pgr_pkg::KIND_ADD:
                            begin
                                out_load = 1'b1;
                                if (({1'b0, in_ch.source_node} >= n_act) ||
                                    ({1'b0, in_ch.target_node} >= n_act))
                                    load_status = pgr_pkg::STAT_RANGE;
                                else if (edge_count_reg == EC'(pgr_pkg::EDGES_MAX))
                                    load_status = pgr_pkg::STAT_FULL;
                                else
                                begin
                                    edge_we         = 1'b1;
                                    edge_wa         = edge_count_reg[EW-1:0];
                                    edge_wd         = {in_ch.source_node, in_ch.target_node};
                                    deg_re          = 1'b1;
                                    deg_ra          = in_ch.source_node;
                                    src_next        = in_ch.source_node;
                                    edge_count_next = edge_count_reg + 1'b1;
                                    state_next      = S_ADD;
                                end
                            end
                            pgr_pkg::KIND_RUN:
                                state_next = S_PREP0;
                            pgr_pkg::KIND_READ:
                            begin
                                if ({1'b0, in_ch.node_index} >= n_act)
                                begin
                                    out_load    = 1'b1;
                                    load_status = pgr_pkg::STAT_RANGE;
                                end
                                else
                                begin
                                    rcur_re    = 1'b1;
                                    rcur_ra    = in_ch.node_index;
                                    state_next = S_RDR;
                                end
                            end
                            default:
                            begin
                                clr_report_next = 1'b1;
                                i_next          = '0;
                                state_next      = S_CLR;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    deg_we     = 1'b1;
                    deg_wa     = src_reg;
                    deg_wd     = deg_q + 1'b1;
                    state_next = S_IDLE;
                end
                S_RDR:
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        load_rank  = rcur_q;
                        state_next = S_IDLE;
                    end
                end
                S_PREP0:
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b1, {RW{1'b0}}};
                    div_req.divisor  = DW'(n_act);
                    state_next       = S_PREP1;
                end
                S_PREP1:
                begin
                    if (!div_busy)
                    begin
                        init_next        = div_q[RW] ? RANK_MAX : div_q[RW-1:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = {(17'h10000 - {1'b0, damping_reg}), 16'd0}
                                           + pgr_pkg::DIVD_W'(n_act >> 1);
                        div_req.divisor  = DW'(n_act);
                        state_next       = S_PREP2;
                    end
                end
                S_PREP2:
                begin
                    if (!div_busy)
                    begin
                        delta_next = div_q;
                        i_next     = '0;
                        state_next = S_INIT;
                    end
                end
                S_INIT:
                begin
                    rcur_we = 1'b1;
                    rcur_wa = i_reg[NW-1:0];
                    rcur_wd = init_reg;
                    i_next  = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_act)
                    begin
                        i_next      = '0;
                        dang_next   = '0;
                        err_next    = '0;
                        passes_next = '0;
                        state_next  = S_A_RD;
                    end
                end
                S_A_RD:
                begin
                    rcur_re    = 1'b1;
                    rcur_ra    = i_reg[NW-1:0];
                    deg_re     = 1'b1;
                    deg_ra     = i_reg[NW-1:0];
                    rnext_we   = 1'b1;
                    rnext_wa   = i_reg[NW-1:0];
                    rnext_wd   = '0;
                    state_next = S_A_DIV;
                end
                S_A_DIV:
                begin
                    div_req.start = 1'b1;
                    state_next    = S_A_WT;
                end
                S_A_WT:
                begin
                    if (!div_busy)
                    begin
                        if (deg_q == '0)
                            dang_next = sum_dang[RW] ? RANK_MAX : sum_dang[RW-1:0];
                        else
                        begin
                            share_we = 1'b1;
                            share_wa = i_reg[NW-1:0];
                            share_wd = div_q[RW-1:0];
                        end
                        i_next     = i_reg + 1'b1;
                        state_next = S_A_RD;
                        if (i_reg + 1'b1 == n_act)
                        begin
                            e_next     = '0;
                            state_next = S_B_RD;
                        end
                    end
                end
                S_B_RD:
                begin
                    if (e_reg == edge_count_reg)
                    begin
                        i_next     = '0;
                        state_next = S_C_RD;
                    end
                    else
                    begin
                        edge_re    = 1'b1;
                        edge_ra    = e_reg[EW-1:0];
                        state_next = S_B_LK;
                    end
                end
                S_B_LK:
                begin
                    deg_re     = 1'b1;
                    deg_ra     = e_src;
                    share_re   = 1'b1;
                    share_ra   = e_src;
                    rnext_re   = 1'b1;
                    rnext_ra   = e_tgt;
                    flag_next  = e_ok;
                    tgt_next   = e_tgt;
                    state_next = S_B_WR;
                end
                S_B_WR:
                begin
                    // edges beyond the node count are skipped; their source
                    // still counts them, so that share is lost
                    if (flag_reg && (deg_q != '0))
                    begin
                        rnext_we = 1'b1;
                        rnext_wa = tgt_reg;
                        rnext_wd = sum_share[RW] ? RANK_MAX : sum_share[RW-1:0];
                    end
                    e_next     = e_reg + 1'b1;
                    state_next = S_B_RD;
                end
                S_C_RD:
                begin
                    rnext_re   = 1'b1;
                    rnext_ra   = i_reg[NW-1:0];
                    rcur_re    = 1'b1;
                    rcur_ra    = i_reg[NW-1:0];
                    state_next = S_C_MUL;
                end
                S_C_MUL:
                begin
                    prod_next  = v1 * damping_reg;
                    state_next = S_C_WR;
                end
                S_C_WR:
                begin
                    rcur_we = 1'b1;
                    rcur_wa = i_reg[NW-1:0];
                    rcur_wd = v3;
                    if (diff > err_reg)
                        err_next = diff;
                    i_next     = i_reg + 1'b1;
                    state_next = S_C_RD;
                    if (i_reg + 1'b1 == n_act)
                    begin
                        // end of pass: decide on another one
                        i_next = '0;
                        if ((((diff > err_reg) ? diff : err_reg) > tolerance_reg) &&
                            (pn < cap))
                        begin
                            passes_next = pn;
                            dang_next   = '0;
                            err_next    = '0;
                            state_next  = S_A_RD;
                        end
                        else
                        begin
                            iter_next       = pn;
                            res_status_next = ((((diff > err_reg) ? diff : err_reg))
                                               > tolerance_reg)
                                              ? pgr_pkg::STAT_NOCONV : pgr_pkg::STAT_OK;
                            fin_next        = F_DONE;
                            state_next      = S_IDLE;
                        end
                    end
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            fin_reg        <= F_NONE;
            i_reg          <= '0;
            e_reg          <= '0;
            edge_count_reg <= '0;
            clr_report_reg <= 1'b0;
            passes_reg     <= '0;
            iter_reg       <= '0;
            res_status_reg <= pgr_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_reg        <= fin_next;
            i_reg          <= i_next;
            e_reg          <= e_next;
            edge_count_reg <= edge_count_next;
            clr_report_reg <= clr_report_next;
            passes_reg     <= passes_next;
            iter_reg       <= iter_next;
            res_status_reg <= res_status_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        init_reg  <= init_next;
        delta_reg <= delta_next;
        dang_reg  <= dang_next;
        err_reg   <= err_next;
        flag_reg  <= flag_next;
        tgt_reg   <= tgt_next;
        src_reg   <= src_next;
        prod_reg  <= prod_next;
        if (out_load)
        begin
            out_rank_reg   <= load_rank;
            out_iter_reg   <= load_iter;
            out_status_reg <= load_status;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.rank       = out_rank_reg;
    assign out_ch.iterations = out_iter_reg;
    assign out_ch.status     = out_status_reg;

`ifndef SYNTHESIS
    // no request may start while the divider is still working
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !div_busy)
        else $error("request accepted while divider busy");

    a_edge_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= EC'(pgr_pkg::EDGES_MAX))
        else $error("edge count beyond store size");

    // a pass in progress never exceeds the iteration cap
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_WR) |-> (passes_reg < cap))
        else $error("pass count reached cap mid-run");

    // a loaded result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overrun");
`endif

endmodule

// ----- verif/testbench.sv -----
// Testbench of the PageRank engine: directed and random requests, scoreboard of results.
`timescale 1ns / 1ps

module testbench;
    import pgr_pkg::*;

    typedef struct {
        logic [31:0] rank;
        logic [15:0] iterations;
        pgr_status_t status;
    } rank_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pgr_in_if  in_if ();
    pgr_out_if out_if ();

    pagerank_power_iteration u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the engine: registers, graph and ranks.
    // ------------------------------------------------------------------
    logic [10:0]     shadow_nodes;
    logic [15:0]     shadow_damping;
    logic [31:0]     shadow_tolerance;
    logic [15:0]     shadow_cap;

    logic [9:0]      link_src [EDGES_MAX];
    logic [9:0]      link_dst [EDGES_MAX];
    int unsigned     degree   [NODES_MAX];
    int unsigned     link_count;
    longint unsigned rank_now [NODES_MAX];
    longint unsigned rank_new [NODES_MAX];
    bit              rank_valid [NODES_MAX];   // node rank written by some run
    logic [15:0]     pass_count;

    rank_result_t    pending_results [$];      // results still owed by the engine

    int  errors;
    int  requests_sent;
    int  results_seen;
    int  status_seen [4];
    int  runs_seen;
    bit  idle_on;          // random gaps on both sides
    int  hold_cycles;      // long receiver hold-off, consumed by the receiver process

    localparam longint unsigned RANK_SAT = 64'hFFFF_FFFF;

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned clip_rank(longint unsigned v);
        return (v > RANK_SAT) ? RANK_SAT : v;
    endfunction

    function automatic int unsigned nodes_in_use();
        if (shadow_nodes == 0) return 1;
        if (shadow_nodes > NODES_MAX) return NODES_MAX;
        return shadow_nodes;
    endfunction

    // Full power iteration; returns the run status.
    function automatic pgr_status_t iterate_ranks();
        int unsigned     n;
        int unsigned     cap;
        int unsigned     passes;
        longint unsigned p;
        longint unsigned tol;
        longint unsigned init;
        longint unsigned teleport;
        longint unsigned err;
        longint unsigned dang;
        longint unsigned v;
        longint unsigned d;
        n        = nodes_in_use();
        cap      = (shadow_cap == 0) ? 1 : shadow_cap;
        p        = shadow_damping;
        tol      = shadow_tolerance;
        init     = clip_rank((64'd1 << 32) / n);
        teleport = (((65536 - p) << 16) + n / 2) / n;
        passes   = 0;
        err      = 0;
        for (int i = 0; i < n; i++)
        begin
            rank_now[i]   = init;
            rank_valid[i] = 1'b1;
        end
        do
        begin
            dang = 0;
            for (int i = 0; i < n; i++)
            begin
                rank_new[i] = 0;
                if (degree[i] == 0) dang = add_sat(dang, rank_now[i] / n);
            end
            for (int e = 0; e < link_count; e++)
            begin
                if (link_src[e] < n && link_dst[e] < n && degree[link_src[e]] != 0)
                    rank_new[link_dst[e]] = add_sat(rank_new[link_dst[e]],
                                                    rank_now[link_src[e]] / degree[link_src[e]]);
            end
            err = 0;
            for (int i = 0; i < n; i++)
            begin
                v = clip_rank(add_sat(rank_new[i], dang));
                v = (v * p + 64'h8000) >> 16;
                v = clip_rank(add_sat(v, teleport));
                d = (v > rank_now[i]) ? v - rank_now[i] : rank_now[i] - v;
                if (d > err) err = d;
                rank_new[i] = v;
            end
            for (int i = 0; i < n; i++) rank_now[i] = rank_new[i];
            passes++;
        end
        while (err > tol && passes < cap);
        pass_count = passes[15:0];
        return (err > tol) ? STAT_NOCONV : STAT_OK;
    endfunction

    // Expected result of one accepted request; updates the shadow state.
    function automatic rank_result_t predict_result(pgr_kind_t kind, logic [9:0] src,
                                                    logic [9:0] dst, logic [9:0] idx);
        rank_result_t r;
        int unsigned  n;
        n        = nodes_in_use();
        r.rank   = '0;
        r.status = STAT_OK;
        case (kind)
            KIND_ADD:
            begin
                if (src >= n || dst >= n) r.status = STAT_RANGE;
                else if (link_count >= EDGES_MAX) r.status = STAT_FULL;
                else
                begin
                    link_src[link_count] = src;
                    link_dst[link_count] = dst;
                    degree[src]++;
                    link_count++;
                end
            end
            KIND_RUN:
                r.status = iterate_ranks();
            KIND_READ:
            begin
                if (idx >= n) r.status = STAT_RANGE;
                else r.rank = rank_now[idx][31:0];
            end
            default:
            begin
                foreach (degree[i]) degree[i] = 0;
                link_count = 0;
            end
        endcase
        r.iterations = pass_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    always #5 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("timeout at %0t", $time);
        $display("** pagerank_power_iteration: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random ready, optional long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_if.ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = idle_on ? $urandom_range(0, 19) : 0;
            if (gap > 0)
            begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_if.ready = 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
        end
    end

    // Scoreboard: each result against the oldest expectation.
    always @(posedge clk)
    begin
        rank_result_t exp_r;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            results_seen++;
            status_seen[out_if.status]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result rank=%h iterations=%0d status=%0d",
                         $time, out_if.rank, out_if.iterations, out_if.status);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_if.rank !== exp_r.rank)
                begin
                    $display("%0t: rank expected %h actual %h", $time, exp_r.rank, out_if.rank);
                    errors++;
                end
                if (out_if.iterations !== exp_r.iterations)
                begin
                    $display("%0t: iterations expected %0d actual %0d",
                             $time, exp_r.iterations, out_if.iterations);
                    errors++;
                end
                if (out_if.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, out_if.status);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // One request; the prediction is taken at the accepting edge.
    task automatic send_request(pgr_kind_t kind, logic [9:0] src, logic [9:0] dst,
                                logic [9:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.kind        = kind;
        in_if.source_node = src;
        in_if.target_node = dst;
        in_if.node_index  = idx;
        in_if.valid       = 1'b1;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        pending_results.push_back(predict_result(kind, src, dst, idx));
        requests_sent++;
        if (kind == KIND_RUN) runs_seen++;
    endtask

    // Stop offering, then wait until every owed result is back.
    task automatic drain_results();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup then access phase; only called with the engine idle.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (index)
            REG_NODE_COUNT: shadow_nodes     = value[10:0];
            REG_DAMPING:    shadow_damping   = value[15:0];
            REG_TOLERANCE:  shadow_tolerance = value;
            default:        shadow_cap       = value[15:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(logic [10:0] nodes, logic [15:0] damp, logic [31:0] tol,
                             logic [15:0] cap);
        drain_results();
        write_reg(REG_NODE_COUNT, {21'd0, nodes});
        write_reg(REG_DAMPING, {16'd0, damp});
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_MAX_ITER, {16'd0, cap});
    endtask

    // Read of a node; never touches a rank that no run has written.
    task automatic read_node(logic [9:0] idx);
        if (idx < nodes_in_use() && !rank_valid[idx])
            idx = (nodes_in_use() < NODES_MAX) ? 10'(nodes_in_use()) : 10'd0;
        if (idx < nodes_in_use() && !rank_valid[idx]) return;
        send_request(KIND_READ, 10'($urandom), 10'($urandom), idx);
    endtask

    task automatic add_link(logic [9:0] src, logic [9:0] dst);
        send_request(KIND_ADD, src, dst, 10'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: single node, default damping/tolerance/cap.
    task automatic test_defaults();
        read_node(10'd5);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'd0);
        add_link(10'd0, 10'd0);                    // self loop
        add_link(10'd1, 10'd0);                    // out of range
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'd0);
        send_request(KIND_CLEAR, 0, 0, 0);
    endtask

    // Small ring with a dangling node, damping extremes, cap zero, shrink.
    task automatic test_small_graph();
        configure(11'd4, 16'hFFFF, 32'd0, 16'd5);
        add_link(10'd0, 10'd1);
        add_link(10'd1, 10'd2);
        add_link(10'd2, 10'd0);
        add_link(10'd4, 10'd0);                    // source out of range
        add_link(10'd0, 10'h3FF);                  // target out of range
        send_request(KIND_RUN, 0, 0, 0);           // node 3 dangling, not converged
        for (int i = 0; i < 4; i++) read_node(10'(i));
        read_node(10'd4);
        read_node(10'h3FF);
        configure(11'd4, 16'd0, TOLERANCE_RST, 16'd0);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'd2);
        send_request(KIND_CLEAR, 0, 0, 0);
        send_request(KIND_RUN, 0, 0, 0);           // every node dangling
        read_node(10'd1);
        add_link(10'd0, 10'd3);
        add_link(10'd3, 10'd1);
        add_link(10'd1, 10'd0);
        configure(11'd2, DAMPING_RST, TOLERANCE_RST, 16'd20);
        send_request(KIND_RUN, 0, 0, 0);           // links to node 3 lose their share
        read_node(10'd0);
        read_node(10'd1);
        read_node(10'd3);
        send_request(KIND_CLEAR, 0, 0, 0);
    endtask

    // Node count at and beyond its maximum, highest node indexes.
    task automatic test_large_graph();
        configure(11'd2047, DAMPING_RST, 32'd0, 16'd1);
        add_link(10'h3FF, 10'd0);
        add_link(10'd0, 10'h3FF);
        add_link(10'h2AA, 10'h155);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'h3FF);
        configure(11'd1024, DAMPING_RST, 32'd0, 16'd2);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'h3FF);
        read_node(10'h200);
        send_request(KIND_CLEAR, 0, 0, 0);
    endtask

    // Node count zero and the top iteration cap.
    task automatic test_cap_limits();
        configure(11'd0, 16'd32768, 32'd0, 16'hFFFF);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'd0);
        read_node(10'd1);
        configure(11'd3, 16'd40000, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(KIND_RUN, 0, 0, 0);
        read_node(10'd2);
    endtask

    // Long receiver hold-off while requests keep coming, then a full drain.
    task automatic test_backpressure();
        configure(11'd3, DAMPING_RST, TOLERANCE_RST, 16'd30);
        send_request(KIND_CLEAR, 0, 0, 0);
        drain_results();
        hold_cycles = 300;
        @(posedge clk);
        for (int i = 0; i < 12; i++)
        begin
            add_link(10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)));
            read_node(10'($urandom_range(0, 3)));
        end
        send_request(KIND_RUN, 0, 0, 0);
        drain_results();                           // sender waits for everything
        for (int i = 0; i < 3; i++) read_node(10'(i));
    endtask

    // Random graphs: configure, load, maybe shrink, run, read back.
    task automatic test_random();
        int unsigned n;
        int unsigned links;
        int unsigned reads;
        logic [31:0] tol;
        while (requests_sent < 840)
        begin
            n = $urandom_range(1, 10);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 0 : 11;
            case ($urandom_range(0, 3))
                0:       tol = 32'd0;
                1:       tol = $urandom;
                default: tol = $urandom_range(0, 2000000);
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            configure(11'(n), 16'($urandom), tol, 16'($urandom_range(1, 30)));
            n = nodes_in_use();
            if ($urandom_range(0, 1)) send_request(KIND_CLEAR, 0, 0, 0);
            links = $urandom_range(0, 20);
            for (int i = 0; i < links; i++)
            begin
                if ($urandom_range(0, 5) == 0) add_link(10'($urandom), 10'($urandom));
                else add_link(10'($urandom_range(0, n - 1)), 10'($urandom_range(0, n - 1)));
                if ($urandom_range(0, 7) == 0) read_node(10'($urandom));
            end
            if ($urandom_range(0, 4) == 0 && n > 1)
            begin
                drain_results();
                write_reg(REG_NODE_COUNT, $urandom_range(1, n - 1));
                n = nodes_in_use();
            end
            send_request(KIND_RUN, 0, 0, 0);
            reads = $urandom_range(1, 8);
            for (int i = 0; i < reads; i++)
            begin
                if ($urandom_range(0, 3) == 0) read_node(10'($urandom));
                else read_node(10'($urandom_range(0, n - 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_if.valid = 1'b0;
        in_if.kind  = KIND_ADD;
        in_if.source_node = '0;
        in_if.target_node = '0;
        in_if.node_index  = '0;
        errors        = 0;
        requests_sent = 0;
        results_seen  = 0;
        runs_seen     = 0;
        hold_cycles   = 0;
        idle_on       = 1'b1;
        foreach (status_seen[i]) status_seen[i] = 0;
        shadow_nodes     = NODE_COUNT_RST;
        shadow_damping   = DAMPING_RST;
        shadow_tolerance = TOLERANCE_RST;
        shadow_cap       = MAX_ITER_RST;
        foreach (degree[i])
        begin
            degree[i]     = 0;
            rank_now[i]   = 0;
            rank_valid[i] = 1'b0;
        end
        link_count = 0;
        pass_count = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_small_graph();
        test_large_graph();
        test_cap_limits();
        test_backpressure();
        test_random();

        drain_results();
        repeat (100) @(posedge clk);
        $display("covered %0d requests, %0d results, %0d runs", requests_sent,
                 results_seen, runs_seen);
        $display("status ok/range/full/noconv: %0d/%0d/%0d/%0d", status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && pending_results.size() == 0)
            $display("** pagerank_power_iteration: PASSED **");
        else
            $display("** pagerank_power_iteration: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pgr_pkg.sv
hdl/pgr_in_if.sv
hdl/pgr_out_if.sv
hdl/pgr_div.sv
hdl/pagerank_power_iteration.sv
verif/testbench.sv
